[sv/gws_pkg.sv]
// Shared types, constants and functions of the Gerstner wave surface block.
package gws_pkg;

	localparam int WAVE_COUNT       = 5;
	localparam int TRIG_TABLE_DEPTH = 1024;
	localparam int IDX_W            = $clog2(TRIG_TABLE_DEPTH);
	localparam int WSEL_W           = (WAVE_COUNT > 1) ? $clog2(WAVE_COUNT) : 1;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_WAVE_LAST = 3'd4;
	localparam logic [2:0] REG_ACTIVE    = 3'd5;
	localparam logic [2:0] REG_HEIGHT    = 3'd6;

	localparam logic [21:0] INV_TWO_PI_Q24  = 22'd2670177;
	localparam logic [30:0] TWO_PI_Q28      = 31'd1686629713;
	localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
	localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam int CORDIC_STEPS = 20;

	typedef logic signed [15:0] norm_t;

	// One item and its running sums, handed from cell to cell
	typedef struct packed {
		logic signed [12:0] rx;
		logic signed [12:0] rz;
		logic [19:0]        t;
		logic signed [45:0] sx;
		logic signed [31:0] sy;
		logic signed [45:0] sz;
	} item_t;

	// Write port of the trig tables, driven by the setup unit
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		logic [33:0]      cs;
	} fill_t;

	// Arctangent of 2^-i in Q.28
	function automatic logic [27:0] atan_q28(input logic [4:0] i);
		logic [27:0] r;
		case (i)
			5'd0:  r = 28'd210828714;
			5'd1:  r = 28'd124459457;
			5'd2:  r = 28'd65760959;
			5'd3:  r = 28'd33381290;
			5'd4:  r = 28'd16755422;
			5'd5:  r = 28'd8385879;
			5'd6:  r = 28'd4193963;
			5'd7:  r = 28'd2097109;
			5'd8:  r = 28'd1048571;
			5'd9:  r = 28'd524287;
			5'd10: r = 28'd262144;
			5'd11: r = 28'd131072;
			5'd12: r = 28'd65536;
			5'd13: r = 28'd32768;
			5'd14: r = 28'd16384;
			5'd15: r = 28'd8192;
			5'd16: r = 28'd4096;
			5'd17: r = 28'd2048;
			5'd18: r = 28'd1024;
			5'd19: r = 28'd512;
			default: r = 28'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		logic signed [15:0] r;
		if (v > 48'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -48'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

[sv/gws_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/gws_setup.sv]
// Setup unit: fills the trig tables by CORDIC and normalizes wave vectors.
module gws_setup (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [gws_pkg::WSEL_W-1:0] wsel,
	input  logic [59:0]               wave,
	output logic                      busy,
	output gws_pkg::fill_t            fill,
	output gws_pkg::norm_t            nx [gws_pkg::WAVE_COUNT],
	output gws_pkg::norm_t            nz [gws_pkg::WAVE_COUNT]
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_ROT  = 3'd2;
	localparam logic [2:0] ST_WR   = 3'd3;
	localparam logic [2:0] ST_SQ   = 3'd4;
	localparam logic [2:0] ST_SQRT = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;

	logic [2:0]                  st_q;
	logic [gws_pkg::IDX_W-1:0]   idx_q;
	logic [4:0]                  step_q;
	logic signed [32:0]          a_q;
	logic signed [33:0]          x_q;
	logic signed [33:0]          y_q;
	logic                        flip_q;
	logic signed [11:0]          kx_q;
	logic signed [11:0]          ky_q;
	logic signed [11:0]          kz_q;
	logic [gws_pkg::WSEL_W-1:0]  wsel_q;
	logic [31:0]                 v_q;
	logic [31:0]                 r_q;
	logic [31:0]                 bit_q;
	logic [29:0]                 num_q;
	logic [16:0]                 rem_q;
	logic [29:0]                 quo_q;
	logic                        zsel_q;

	logic [gws_pkg::IDX_W+30:0]  ang_prod;
	logic signed [32:0]          ang;
	logic signed [32:0]          ang_fold;
	logic                        ang_flip;
	logic signed [33:0]          x_sh;
	logic signed [33:0]          y_sh;
	logic signed [33:0]          x_fin;
	logic signed [33:0]          y_fin;
	logic signed [33:0]          c_r;
	logic signed [33:0]          s_r;
	logic [23:0]                 sq_x;
	logic [23:0]                 sq_y;
	logic [23:0]                 sq_z;
	logic [25:0]                 sq_sum;
	logic [31:0]                 sq_try;
	logic [17:0]                 rem_sh;
	logic                        q_bit;
	logic [17:0]                 rem_sub;
	logic [29:0]                 quo_next;
	logic [14:0]                 q_mag;
	logic signed [15:0]          q_signed;
	logic signed [11:0]          k_cur;
	logic [11:0]                 kz_abs;

	// Angle of the table entry, folded into the right half plane
	always_comb begin
		ang_prod = (gws_pkg::IDX_W+31)'(idx_q) * (gws_pkg::IDX_W+31)'(gws_pkg::TWO_PI_Q28);
		ang      = signed'(33'(ang_prod >> gws_pkg::IDX_W));
		if (ang > gws_pkg::PI_Q28) begin
			ang = ang - signed'({2'b00, gws_pkg::TWO_PI_Q28});
		end
		ang_fold = ang;
		ang_flip = 1'b0;
		if (ang > gws_pkg::HALF_PI_Q28) begin
			ang_fold = ang - gws_pkg::PI_Q28;
			ang_flip = 1'b1;
		end else if (ang < -gws_pkg::HALF_PI_Q28) begin
			ang_fold = ang + gws_pkg::PI_Q28;
			ang_flip = 1'b1;
		end
	end

	// CORDIC shifts and final rounding to Q.15
	always_comb begin
		x_sh  = x_q >>> step_q;
		y_sh  = y_q >>> step_q;
		x_fin = flip_q ? -x_q : x_q;
		y_fin = flip_q ? -y_q : y_q;
		c_r   = (x_fin + 34'sd16384) >>> 15;
		s_r   = (y_fin + 34'sd16384) >>> 15;
	end

	// Squared length, square root step and divide step
	always_comb begin
		sq_x     = 24'(kx_q * kx_q);
		sq_y     = 24'(ky_q * ky_q);
		sq_z     = 24'(kz_q * kz_q);
		sq_sum   = 26'(sq_x) + 26'(sq_y) + 26'(sq_z);
		sq_try   = r_q + bit_q;
		rem_sh   = {rem_q, num_q[29]};
		q_bit    = (rem_sh >= 18'(r_q));
		rem_sub  = q_bit ? (rem_sh - 18'(r_q)) : rem_sh;
		quo_next = {quo_q[28:0], q_bit};
		q_mag    = quo_next[14:0];
		k_cur    = zsel_q ? kz_q : kx_q;
		if (r_q == 32'd0) begin
			q_signed = 16'sd0;
		end else if (k_cur < 12'sd0) begin
			q_signed = -signed'({1'b0, q_mag});
		end else begin
			q_signed = signed'({1'b0, q_mag});
		end
		kz_abs = (kz_q < 12'sd0) ? 12'(-kz_q) : 12'(kz_q);
	end

	assign busy = (st_q != ST_IDLE);

	// Table write on the last pass of each entry
	always_comb begin
		fill.we   = (st_q == ST_WR);
		fill.addr = idx_q;
		fill.cs   = {c_r[16:0], s_r[16:0]};
	end

	// Sequence the table fill after reset and the normalization after a wave write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_LOAD;
			idx_q  <= '0;
			step_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						kx_q   <= signed'(wave[35:24]);
						ky_q   <= signed'(wave[47:36]);
						kz_q   <= signed'(wave[59:48]);
						wsel_q <= wsel;
						st_q   <= ST_SQ;
					end
				end
				ST_LOAD: begin
					a_q    <= ang_fold;
					flip_q <= ang_flip;
					x_q    <= gws_pkg::CORDIC_GAIN_Q30;
					y_q    <= '0;
					step_q <= '0;
					st_q   <= ST_ROT;
				end
				ST_ROT: begin
					if (a_q >= 33'sd0) begin
						x_q <= x_q - y_sh;
						y_q <= y_q + x_sh;
						a_q <= a_q - signed'({5'd0, gws_pkg::atan_q28(step_q)});
					end else begin
						x_q <= x_q + y_sh;
						y_q <= y_q - x_sh;
						a_q <= a_q + signed'({5'd0, gws_pkg::atan_q28(step_q)});
					end
					step_q <= step_q + 5'd1;
					if (step_q == 5'(gws_pkg::CORDIC_STEPS - 1)) begin
						st_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (idx_q == gws_pkg::IDX_W'(gws_pkg::TRIG_TABLE_DEPTH - 1)) begin
						st_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q  <= ST_LOAD;
					end
				end
				ST_SQ: begin
					v_q    <= {sq_sum[23:0], 8'd0};
					r_q    <= '0;
					bit_q  <= 32'h4000_0000;
					step_q <= '0;
					st_q   <= ST_SQRT;
				end
				ST_SQRT: begin
					if (v_q >= sq_try) begin
						v_q <= v_q - sq_try;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q  <= bit_q >> 2;
					step_q <= step_q + 5'd1;
					if (step_q == 5'd15) begin
						num_q  <= {((kx_q < 12'sd0) ? 12'(-kx_q) : 12'(kx_q)), 18'd0};
						rem_q  <= '0;
						quo_q  <= '0;
						zsel_q <= 1'b0;
						step_q <= '0;
						st_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= rem_sub[16:0];
					quo_q  <= quo_next;
					num_q  <= {num_q[28:0], 1'b0};
					step_q <= step_q + 5'd1;
					if (step_q == 5'd29) begin
						step_q <= '0;
						rem_q  <= '0;
						quo_q  <= '0;
						if (!zsel_q) begin
							num_q  <= {kz_abs, 18'd0};
							zsel_q <= 1'b1;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the normalized vectors; reset matches the all-zero waves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < gws_pkg::WAVE_COUNT; w++) begin
				nx[w] <= '0;
				nz[w] <= '0;
			end
		end else if (st_q == ST_DIV && step_q == 5'd29) begin
			if (zsel_q) begin
				nz[wsel_q] <= q_signed;
			end else begin
				nx[wsel_q] <= q_signed;
			end
		end
	end

endmodule

[sv/gws_cell.sv]
// One wave cell: phase, table lookup and accumulation of one wave, seven stages.
module gws_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  gws_pkg::item_t     in_item,
	input  logic [59:0]        wave,
	input  gws_pkg::norm_t     nx,
	input  gws_pkg::norm_t     nz,
	input  logic               on,
	input  logic [11:0]        ry,
	input  gws_pkg::fill_t     fill,
	output logic               out_v,
	output gws_pkg::item_t     out_item
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	gws_pkg::item_t item_s1, item_s2, item_s3, item_s4, item_s5, item_s6, item_s7;

	logic signed [24:0] pkx_s1;
	logic signed [24:0] pky_s1;
	logic signed [24:0] pkz_s1;
	logic [31:0]        pft_s1;
	logic [41:0]        p_s2;
	logic [39:0]        mlo_s3;
	logic [23:0]        mhi_s3;
	logic [33:0]        cs_s4;
	logic signed [29:0] ac_s5;
	logic signed [29:0] as_s5;
	logic signed [29:0] ac_s6;
	logic signed [45:0] xs_s6;
	logic signed [45:0] zs_s6;

	logic [11:0]        amp;
	logic [11:0]        freq;
	logic signed [11:0] kx;
	logic signed [11:0] ky;
	logic signed [11:0] kz;
	logic signed [41:0] p_sum;
	logic [41:0]        turns;
	logic [gws_pkg::IDX_W-1:0] idx;
	logic signed [16:0] c_val;
	logic signed [16:0] s_val;

	assign amp  = wave[11:0];
	assign freq = wave[23:12];
	assign kx   = signed'(wave[35:24]);
	assign ky   = signed'(wave[47:36]);
	assign kz   = signed'(wave[59:48]);

	// Phase sum and table index
	always_comb begin
		p_sum = 42'(pkx_s1) + 42'(pky_s1) + 42'(pkz_s1) - signed'({7'd0, pft_s1, 3'd0});
		turns = 42'(mlo_s3) + {mhi_s3, 18'd0};
		idx   = turns[41 -: gws_pkg::IDX_W];
		c_val = signed'(cs_s4[33:17]);
		s_val = signed'(cs_s4[16:0]);
	end

	gws_ram #(
		.WIDTH(34),
		.DEPTH(gws_pkg::TRIG_TABLE_DEPTH)
	) u_trig (
		.clk  (clk),
		.we   (fill.we),
		.waddr(fill.addr),
		.wdata(fill.cs),
		.re   (en),
		.raddr(idx),
		.rdata(cs_s4)
	);

	// Advance the stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Advance the datapath
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			pkx_s1  <= 25'(kx * in_item.rx);
			pky_s1  <= 25'(ky * signed'({1'b0, ry}));
			pkz_s1  <= 25'(kz * in_item.rz);
			pft_s1  <= 32'(freq) * 32'(in_item.t);

			item_s2 <= item_s1;
			p_s2    <= p_sum;

			item_s3 <= item_s2;
			mlo_s3  <= 40'(p_s2[17:0]) * 40'(gws_pkg::INV_TWO_PI_Q24);
			mhi_s3  <= 24'(46'(p_s2[41:18]) * 46'(gws_pkg::INV_TWO_PI_Q24));

			item_s4 <= item_s3;

			item_s5 <= item_s4;
			ac_s5   <= 30'(signed'({1'b0, amp}) * c_val);
			as_s5   <= 30'(signed'({1'b0, amp}) * s_val);

			item_s6 <= item_s5;
			ac_s6   <= ac_s5;
			xs_s6   <= 46'(nx * as_s5);
			zs_s6   <= 46'(nz * as_s5);

			// Add this wave's terms when it is active, else pass the sums through
			item_s7.rx <= item_s6.rx;
			item_s7.rz <= item_s6.rz;
			item_s7.t  <= item_s6.t;
			item_s7.sx <= on ? (item_s6.sx + xs_s6) : item_s6.sx;
			item_s7.sy <= on ? (item_s6.sy + 32'(ac_s6)) : item_s6.sy;
			item_s7.sz <= on ? (item_s6.sz + zs_s6) : item_s6.sz;
		end
	end

	assign out_v    = v_s7;
	assign out_item = item_s7;

endmodule

[sv/gerstner_wave_surface.sv]
// Gerstner wave surface: displaces grid nodes by a sum of configured waves.
//
// Input channel (in_valid/in_stall) takes one node per transaction: rest_x,
// rest_z and phase_time. Output channel (out_valid/out_stall) returns
// surf_x, surf_y, surf_z for each node in order.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
// writes wave_0..wave_4, active_waves and rest_height; write only while idle.
// Nodes pass through the chain of wave cells and then one output register;
// one node enters per cycle while the chain is not held and the setup unit
// is idle, set by the chain of wave cells, each with its own trig table port.
// After reset the setup unit fills the trig tables by CORDIC, entry by entry
// (load, rotate, write); in_stall and cfg_ready hold off until done.
// A wave write starts a normalization of its wave vector, with cfg_ready low
// and in_stall high meanwhile.
// When out_stall is high with a result waiting, the whole chain holds and
// in_stall rises.
module gerstner_wave_surface (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [12:0] rest_x,
	input  logic signed [12:0] rest_z,
	input  logic [19:0]        phase_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] surf_x,
	output logic signed [15:0] surf_y,
	output logic signed [15:0] surf_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [59:0]        cfg_data
);

	logic [59:0]   wave_q [gws_pkg::WAVE_COUNT];
	logic [2:0]    active_q;
	logic [11:0]   height_q;
	logic          out_valid_q;

	logic          en;
	logic          busy;
	logic          cfg_wr;
	logic          wave_wr;
	gws_pkg::fill_t fill;
	gws_pkg::norm_t nx [gws_pkg::WAVE_COUNT];
	gws_pkg::norm_t nz [gws_pkg::WAVE_COUNT];
	logic [3:0]    n_act;

	logic           chain_v    [gws_pkg::WAVE_COUNT+1];
	gws_pkg::item_t chain_item [gws_pkg::WAVE_COUNT+1];
	gws_pkg::item_t last;

	logic signed [32:0] y_rnd;
	logic signed [46:0] x_rnd;
	logic signed [46:0] z_rnd;
	logic signed [47:0] ox;
	logic signed [47:0] oy;
	logic signed [47:0] oz;

	assign en        = !out_valid_q || !out_stall;
	assign in_stall  = !en || busy;
	assign cfg_ready = !busy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign wave_wr   = cfg_wr && (cfg_index <= gws_pkg::REG_WAVE_LAST) &&
		(32'(cfg_index) < gws_pkg::WAVE_COUNT);
	assign n_act     = (32'(active_q) > gws_pkg::WAVE_COUNT) ?
		4'(gws_pkg::WAVE_COUNT) : {1'b0, active_q};

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < gws_pkg::WAVE_COUNT; w++) begin
				wave_q[w] <= '0;
			end
			active_q <= 3'd1;
			height_q <= 12'd1280;
		end else if (cfg_wr) begin
			if (wave_wr) begin
				wave_q[cfg_index[gws_pkg::WSEL_W-1:0]] <= cfg_data;
			end else if (cfg_index == gws_pkg::REG_ACTIVE) begin
				active_q <= cfg_data[2:0];
			end else if (cfg_index == gws_pkg::REG_HEIGHT) begin
				height_q <= cfg_data[11:0];
			end
		end
	end

	gws_setup u_setup (
		.clk   (clk),
		.arst_n(arst_n),
		.start (wave_wr),
		.wsel  (cfg_index[gws_pkg::WSEL_W-1:0]),
		.wave  (cfg_data),
		.busy  (busy),
		.fill  (fill),
		.nx    (nx),
		.nz    (nz)
	);

	// Feed the first cell from the input ports
	always_comb begin
		chain_v[0]         = in_valid && !in_stall;
		chain_item[0].rx   = rest_x;
		chain_item[0].rz   = rest_z;
		chain_item[0].t    = phase_time;
		chain_item[0].sx   = '0;
		chain_item[0].sy   = '0;
		chain_item[0].sz   = '0;
	end

	for (genvar w = 0; w < gws_pkg::WAVE_COUNT; w++) begin : g_cell
		gws_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_v    (chain_v[w]),
			.in_item (chain_item[w]),
			.wave    (wave_q[w]),
			.nx      (nx[w]),
			.nz      (nz[w]),
			.on      (4'(w) < n_act),
			.ry      (height_q),
			.fill    (fill),
			.out_v   (chain_v[w+1]),
			.out_item(chain_item[w+1])
		);
	end

	// Round the sums and offset the rest position
	always_comb begin
		last  = chain_item[gws_pkg::WAVE_COUNT];
		y_rnd = (33'(last.sy) + 33'sd262144) >>> 19;
		x_rnd = (47'(last.sx) + 47'sh1_0000_0000) >>> 33;
		z_rnd = (47'(last.sz) + 47'sh1_0000_0000) >>> 33;
		oy    = signed'({36'd0, height_q}) + 48'(y_rnd);
		ox    = 48'(last.rx) - 48'(x_rnd);
		oz    = 48'(last.rz) - 48'(z_rnd);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain_v[gws_pkg::WAVE_COUNT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			surf_x <= gws_pkg::sat16(ox);
			surf_y <= gws_pkg::sat16(oy);
			surf_z <= gws_pkg::sat16(oz);
		end
	end

	assign out_valid = out_valid_q;

	// No node enters while the setup unit rebuilds tables or vectors
	a_no_input_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> cfg_ready)
		else $error("node accepted while setup busy");

	// A wave write starts a normalization pass
	a_wave_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index <= gws_pkg::REG_WAVE_LAST) |=> !cfg_ready)
		else $error("wave write did not start normalization");

	// A held result leaves the chain frozen
	a_hold_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(chain_v[gws_pkg::WAVE_COUNT]))
		else $error("chain advanced under output hold");

endmodule

[dv/gws_checker.sv]
// Checker for the wave surface block: predicts each node's displacement and compares.
`timescale 1ns / 1ps
module gws_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [12:0] rest_x,
	input  logic signed [12:0] rest_z,
	input  logic [19:0]        phase_time,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] surf_x,
	input  logic signed [15:0] surf_y,
	input  logic signed [15:0] surf_z,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [59:0]        cfg_data,
	output int                 mismatches,
	output int                 pending,
	output int                 nodes_checked
);

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} surf_pos_t;

	surf_pos_t   surf_q[$];
	logic [59:0] wave_cfg[gws_pkg::WAVE_COUNT];
	logic [2:0]  active_cfg;
	logic [11:0] height_cfg;

	// Cos and sin of a table index by 20 CORDIC rotations, rounded to Q.15
	function automatic void trig_lookup(input longint idx, output longint c, output longint s);
		longint atan_tab[20] = '{210828714, 124459457, 65760959, 33381290, 16755422,
			8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
			32768, 16384, 8192, 4096, 2048, 1024, 512};
		longint a, x, y, nx, ny;
		bit flip;
		a = idx * 64'sd1686629713 / gws_pkg::TRIG_TABLE_DEPTH;
		x = 64'sd652032874;
		y = 0;
		flip = 0;
		if (a > 64'sd843314857) a -= 64'sd1686629713;
		if (a > 64'sd421657428) begin
			a -= 64'sd843314857;
			flip = 1;
		end else if (a < -64'sd421657428) begin
			a += 64'sd843314857;
			flip = 1;
		end
		for (int i = 0; i < 20; i++) begin
			if (a >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				a -= atan_tab[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				a += atan_tab[i];
			end
			x = nx;
			y = ny;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = (x + 64'sd16384) >>> 15;
		s = (y + 64'sd16384) >>> 15;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unit_component(input longint k, input longint unsigned len);
		longint unsigned mag;
		longint q;
		if (len == 0) return 0;
		mag = longint'(k < 0 ? -k : k) << 18;
		q = longint'(mag / len);
		return k < 0 ? -q : q;
	endfunction

	function automatic longint clamp16(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Sum the active waves at one node and time
	function automatic surf_pos_t displace_node(input logic signed [12:0] nx_in,
			input logic signed [12:0] nz_in, input logic [19:0] t_in);
		surf_pos_t r;
		longint rx, rz, ry, t, sx, sy, sz, amp, freq, kx, ky, kz, p, turns, c, s, n;
		longint unsigned frac, idx, len, tu;
		rx = nx_in;
		rz = nz_in;
		t = t_in;
		ry = height_cfg;
		sx = 0;
		sy = 0;
		sz = 0;
		n = (active_cfg > gws_pkg::WAVE_COUNT) ? gws_pkg::WAVE_COUNT : active_cfg;
		for (int w = 0; w < n; w++) begin
			amp = wave_cfg[w][11:0];
			freq = wave_cfg[w][23:12];
			kx = longint'($signed(wave_cfg[w][35:24]));
			ky = longint'($signed(wave_cfg[w][47:36]));
			kz = longint'($signed(wave_cfg[w][59:48]));
			p = kx * rx + ky * ry + kz * rz - freq * t * 8;
			turns = p * 64'sd2670177;
			tu = turns;
			frac = (tu >> 18) & 64'hFFFFFF;
			idx = (frac * gws_pkg::TRIG_TABLE_DEPTH) >> 24;
			trig_lookup(idx, c, s);
			len = root_floor(longint'(kx * kx + ky * ky + kz * kz) << 8);
			sy += amp * c;
			sx += unit_component(kx, len) * amp * s;
			sz += unit_component(kz, len) * amp * s;
		end
		r.x = 16'(clamp16(rx - ((sx + (64'sd1 << 32)) >>> 33)));
		r.y = 16'(clamp16(ry + ((sy + (64'sd1 << 18)) >>> 19)));
		r.z = 16'(clamp16(rz - ((sz + (64'sd1 << 32)) >>> 33)));
		return r;
	endfunction

	assign pending = surf_q.size();

	// Track register writes, predict on input transactions, compare on output ones
	always @(posedge clk or negedge arst_n) begin
		surf_pos_t exp_pos;
		if (!arst_n) begin
			for (int i = 0; i < gws_pkg::WAVE_COUNT; i++) wave_cfg[i] <= '0;
			active_cfg <= 3'd1;
			height_cfg <= 12'd1280;
			surf_q.delete();
			mismatches <= 0;
			nodes_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index <= gws_pkg::REG_WAVE_LAST) begin
					if (cfg_index < gws_pkg::WAVE_COUNT) wave_cfg[cfg_index] <= cfg_data;
				end else if (cfg_index == gws_pkg::REG_ACTIVE) begin
					active_cfg <= cfg_data[2:0];
				end else if (cfg_index == gws_pkg::REG_HEIGHT) begin
					height_cfg <= cfg_data[11:0];
				end
			end
			if (in_valid && !in_stall)
				surf_q.push_back(displace_node(rest_x, rest_z, phase_time));
			if (out_valid && !out_stall) begin
				nodes_checked <= nodes_checked + 1;
				if (surf_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result x=%0d y=%0d z=%0d",
							$realtime, surf_x, surf_y, surf_z);
					mismatches <= mismatches + 1;
				end else begin
					exp_pos = surf_q.pop_front();
					if (exp_pos.x !== surf_x || exp_pos.y !== surf_y ||
							exp_pos.z !== surf_z) begin
						if (mismatches < 10)
							$display("%0t: mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
								$realtime, exp_pos.x, exp_pos.y, exp_pos.z,
								surf_x, surf_y, surf_z);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

[dv/testbench.sv]
// Top of the wave surface testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int STALL_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 60;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic signed [12:0] rest_x = '0;
	logic signed [12:0] rest_z = '0;
	logic [19:0]        phase_time = '0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [15:0] surf_x, surf_y, surf_z;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [59:0]        cfg_data = '0;
	int                 mismatches, pending, nodes_checked;
	int                 idle_pct = 0;
	int                 stall_pct = 0;
	int                 quiet_cycles = 0;
	int                 cfg_writes = 0;

	always #10 clk = ~clk;

	gerstner_wave_surface dut (.*);

	gws_checker checker_i (.*);

	// Random receiver stalls
	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_node(input logic [12:0] x, input logic [12:0] z, input logic [19:0] t);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		rest_x <= x;
		rest_z <= z;
		phase_time <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Let every result arrive, then allow for the pipeline to go quiet
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [59:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		cfg_writes++;
	endtask

	function automatic logic [59:0] pack_wave(input logic [11:0] amp, input logic [11:0] freq,
			input logic [11:0] kx, input logic [11:0] ky, input logic [11:0] kz);
		return {kz, ky, kx, freq, amp};
	endfunction

	function automatic logic [59:0] rand_wave();
		return 60'({$urandom, $urandom});
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_node(13'($urandom), 13'($urandom), 20'($urandom));
	endtask

	task automatic random_setup();
		for (int w = 0; w < gws_pkg::WAVE_COUNT; w++) write_reg(3'(w), rand_wave());
		write_reg(gws_pkg::REG_ACTIVE, 60'($urandom_range(7)));
		write_reg(gws_pkg::REG_HEIGHT, 60'($urandom_range(4095)));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset setup: all waves zero, so the rest position comes back
		send_node(13'h1000, 13'h0FFF, 20'd0);
		send_node(13'h0FFF, 13'h1000, 20'hFFFFF);
		send_node('0, '0, 20'd12345);
		drain();

		// Extreme waves, a zero wave vector among them, height at its top
		write_reg(3'd0, pack_wave(12'hFFF, 12'hFFF, 12'h800, 12'h800, 12'h800));
		write_reg(3'd1, pack_wave(12'hFFF, 12'h001, 12'h7FF, 12'h7FF, 12'h7FF));
		write_reg(3'd2, pack_wave(12'hFFF, 12'd100, 12'h000, 12'h000, 12'h000));
		write_reg(3'd3, pack_wave(12'd2000, 12'd300, 12'h7FF, 12'h000, 12'h800));
		write_reg(gws_pkg::REG_WAVE_LAST, pack_wave(12'd0, 12'd0, 12'h100, 12'h001, 12'hF00));
		write_reg(gws_pkg::REG_ACTIVE, 60'd5);
		write_reg(gws_pkg::REG_HEIGHT, 60'd4095);
		send_node(13'h1000, 13'h1000, 20'd0);
		send_node(13'h0FFF, 13'h0FFF, 20'hFFFFF);
		send_node(13'h1000, 13'h0FFF, 20'd1);
		send_node(13'h0FFF, 13'h1000, 20'h80000);
		send_node('0, '0, 20'd0);
		send_node('0, '0, 20'hFFFFF);
		drain();

		// No wave summed, then a count past the wave total, stray index, zero height
		write_reg(gws_pkg::REG_ACTIVE, 60'd0);
		write_reg(REG_UNUSED, 60'hFFF_FFFF_FFFF_FFFF);
		write_reg(gws_pkg::REG_HEIGHT, 60'd0);
		send_node(13'h1000, 13'h0FFF, 20'd777);
		send_node(13'h0FFF, 13'h1000, 20'hFFFFF);
		drain();
		write_reg(gws_pkg::REG_ACTIVE, 60'd7);
		send_node(13'h1000, 13'h1000, 20'hFFFFF);
		send_node(13'h0FFF, 13'h0FFF, 20'd3);
		drain();
		write_reg(gws_pkg::REG_ACTIVE, 60'd6);
		send_node(13'h0ABC, 13'h1543, 20'd54321);
		drain();

		// Random phases, a fresh setup per quarter of each idling mode
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 87; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 87; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			for (int k = 0; k < 4; k++) begin
				random_setup();
				send_random(64);
				drain();
			end
		end
		idle_pct = 0;
		stall_pct = 0;
		send_random(20);
		drain();

		$display("Checked %0d nodes over %0d register writes, four idling modes.",
			nodes_checked, cfg_writes);
		if (mismatches == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[files.f]
sv/gws_pkg.sv
sv/gws_ram.sv
sv/gws_setup.sv
sv/gws_cell.sv
sv/gerstner_wave_surface.sv
dv/gws_checker.sv
dv/testbench.sv
